/* sv/pee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg: shared definitions for the prefix expression evaluator
// Character codes, status codes, operation codes and the request/response
// types between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package pee_pkg;

  // Default operand stack depth
  localparam int STACK_DEPTH_DEF = 32;

  // Value width
  localparam int VAL_W = 32;

  // ASCII codes of interest
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Arithmetic unit operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } alu_rsp_t;

endpackage

/* sv/pee_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_alu: shared arithmetic unit
// Add, subtract and low-word multiply finish in the cycle after start. Signed
// division runs a restoring shift-subtract loop, one quotient bit per cycle,
// and truncates toward zero. The divisor is never zero here.
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  pee_pkg::alu_req_t req,
  output pee_pkg::alu_rsp_t rsp
);
  import pee_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  logic             busy_r;
  logic             fin_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] quo_r;
  logic [VAL_W-1:0] dvs_r;
  logic [VAL_W-1:0] res_r;

  logic [VAL_W-1:0] abs_a;
  logic [VAL_W-1:0] abs_b;
  logic [VAL_W:0]   rem_sh;
  logic [VAL_W:0]   rem_dif;

  // Magnitudes of the operands
  assign abs_a = req.a[VAL_W-1] ? (~req.a + 1'b1) : req.a;
  assign abs_b = req.b[VAL_W-1] ? (~req.b + 1'b1) : req.b;

  // One restoring division step
  assign rem_sh  = {rem_r, quo_r[VAL_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        if (req.op == OP_DIV) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.op)
        OP_ADD:  res_r <= req.a + req.b;
        OP_SUB:  res_r <= req.a - req.b;
        OP_MUL:  res_r <= req.a * req.b;
        default: begin
          rem_r <= '0;
          quo_r <= abs_a;
          dvs_r <= abs_b;
          neg_r <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
        end
      endcase
    end else if (busy_r) begin
      if (!rem_dif[VAL_W]) begin
        rem_r <= rem_dif[VAL_W-1:0];
        quo_r <= {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[VAL_W-1:0];
        quo_r <= {quo_r[VAL_W-2:0], 1'b0};
      end
    end else if (fin_r) begin
      res_r <= neg_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

/* sv/prefix_expression_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_expression_evaluator: stack-based prefix expression evaluation
// Takes expression characters right to left; digits push, operators pop the
// left then the right operand and push the result. The last character emits
// the top of stack and a sticky status, then clears the stack.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Direction
//  --------+-------------------------------+----------
//  input   | in_valid in_stall in_symbol   | in (stall out)
//          | in_last                       |
//  result  | out_valid out_stall out_value | out (stall in)
//          | out_status                    |
//
//  A digit is pushed when accepted; any other symbol pops the left operand,
//  then the right one, then dispatches. Add/sub/multiply then wait on the
//  shared unit; a nonzero divide runs 32 quotient bits, one per cycle, then
//  sign fix-up and handoff in the shared unit. A last character then reads the top.
//  Synchronous active-low reset empties the stack and clears the status.
//  in_stall is high while a transaction is in progress; a result waiting on
//  out_stall blocks only the next final character.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_symbol,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [pee_pkg::VAL_W-1:0] out_value,
  output logic [1:0]                 out_status
);
  import pee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POPB  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_ALU   = 3'd3;
  localparam logic [2:0] S_RDTOP = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [7:0]       sym_r;
  logic             last_r;
  logic             a_empty_r, a_empty_nxt;
  logic             b_empty_r, b_empty_nxt;
  logic [VAL_W-1:0] a_r, a_nxt;
  logic [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             push_en;
  logic [VAL_W-1:0] push_val;
  logic             wr_en;
  logic             note_under, note_divz;
  logic             out_load;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic [1:0]       out_status_r;
  logic             in_accept;
  logic [2:0]       after_item;
  logic [VAL_W-1:0] b_val;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  logic [VAL_W-1:0] stack_mem [STACK_DEPTH];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign after_item = last_r ? S_RDTOP : S_IDLE;
  assign b_val     = b_empty_r ? '0 : rd_data_r;
  assign rd_addr   = AW'(count_r - 1'b1);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    err_nxt     = err_r;
    a_nxt       = a_r;
    a_empty_nxt = a_empty_r;
    b_empty_nxt = b_empty_r;
    push_en     = 1'b0;
    push_val    = '0;
    wr_en       = 1'b0;
    note_under  = 1'b0;
    note_divz   = 1'b0;
    out_load    = 1'b0;
    alu_req     = '0;
    alu_req.a   = a_r;
    alu_req.b   = b_val;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_symbol inside {[CH_0:CH_9]}) begin
            push_en   = 1'b1;
            push_val  = {{(VAL_W-8){1'b0}}, in_symbol - CH_0};
            state_nxt = in_last ? S_RDTOP : S_IDLE;
          end else begin
            // Pop the left operand
            if (count_r == '0) begin
              a_empty_nxt = 1'b1;
              note_under  = 1'b1;
            end else begin
              a_empty_nxt = 1'b0;
              count_nxt   = count_r - 1'b1;
            end
            state_nxt = S_POPB;
          end
        end
      end
      S_POPB: begin
        a_nxt = a_empty_r ? '0 : rd_data_r;
        // Pop the right operand
        if (count_r == '0) begin
          b_empty_nxt = 1'b1;
          note_under  = 1'b1;
        end else begin
          b_empty_nxt = 1'b0;
          count_nxt   = count_r - 1'b1;
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sym_r)
          CH_PLUS: begin
            alu_req.start = 1'b1;
            alu_req.op    = OP_ADD;
            state_nxt     = S_ALU;
          end
          CH_MINUS: begin
            alu_req.start = 1'b1;
            alu_req.op    = OP_SUB;
            state_nxt     = S_ALU;
          end
          CH_STAR: begin
            alu_req.start = 1'b1;
            alu_req.op    = OP_MUL;
            state_nxt     = S_ALU;
          end
          CH_SLASH: begin
            if (b_val == '0) begin
              note_divz = 1'b1;
              push_en   = 1'b1;
              state_nxt = after_item;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = OP_DIV;
              state_nxt     = S_ALU;
            end
          end
          default: state_nxt = after_item;
        endcase
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          push_en   = 1'b1;
          push_val  = alu_rsp.result;
          state_nxt = after_item;
        end
      end
      S_RDTOP: state_nxt = S_OUT;
      S_OUT: begin
        // Emit once the output register is free, then clear
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Record the first error only
    if (note_under && err_nxt == ST_OK) begin
      err_nxt = ST_UNDER;
    end
    if (note_divz && err_nxt == ST_OK) begin
      err_nxt = ST_DIVZ;
    end

    // Push, dropping it on a full stack
    if (push_en) begin
      if (count_r == CW'(STACK_DEPTH)) begin
        if (err_nxt == ST_OK) begin
          err_nxt = ST_OVER;
        end
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and operand registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    a_r       <= a_nxt;
    a_empty_r <= a_empty_nxt;
    b_empty_r <= b_empty_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= (count_r == '0) ? '0 : rd_data_r;
      out_status_r <= (count_r == '0 && err_r == ST_OK) ? ST_UNDER : err_r;
    end
  end

  // Operand stack: write at the fill level, read the top
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count_r[AW-1:0]] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= stack_mem[rd_addr];
  end

  pee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (count_r == '0 && err_r == ST_OK))
    else $error("stack not cleared after result");

  a_alu_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_ALU))
    else $error("arithmetic result outside wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside output state");

endmodule

/* test/prefix_expression_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_test: self-checking bench for the evaluator
// Feeds prefix expressions right to left through the valid/stall input port
// and predicts each result with a local operand stack. Covers directed corner
// cases, then random well-formed expressions mixed with noise and broken
// sequences. Random idle gaps sit on both sides, and one long receiver hold
// backs the block up into its input.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_test;
  import pee_pkg::*;

  localparam int STACK_DEPTH      = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS     = 1500;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 60;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
  } feed_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_symbol = 8'd0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_value;
  logic [1:0] out_status;

  feed_item_t   pending_items[$];
  eval_result_t expected_results[$];

  int total_items = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int fail_count = 0;

  // Local copy of the evaluator state
  logic [VAL_W-1:0] model_stack [STACK_DEPTH];
  int               model_depth = 0;
  logic [1:0]       model_status = ST_OK;

  prefix_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_status(out_status)
  );

  // Clock: 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hold reset low at the start, then release it
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Keep only the first error of an expression
  function automatic void note_status(logic [1:0] code);
    if (model_status == ST_OK) model_status = code;
  endfunction

  // Drop a push onto a full stack
  function automatic void stack_push(logic [VAL_W-1:0] v);
    if (model_depth >= STACK_DEPTH) begin
      note_status(ST_OVER);
    end else begin
      model_stack[model_depth] = v;
      model_depth++;
    end
  endfunction

  // Read a missing operand as zero
  function automatic logic [VAL_W-1:0] stack_pop();
    if (model_depth == 0) begin
      note_status(ST_UNDER);
      return '0;
    end
    model_depth--;
    return model_stack[model_depth];
  endfunction

  // Apply one symbol; on the last one, queue the expected result
  function automatic void evaluate_symbol(logic [7:0] sym, logic fin);
    logic [VAL_W-1:0] lhs;
    logic [VAL_W-1:0] rhs;
    longint           quotient;
    eval_result_t     res;
    if (sym >= CH_0 && sym <= CH_9) begin
      stack_push({24'd0, sym - CH_0});
    end else begin
      lhs = stack_pop();
      rhs = stack_pop();
      case (sym)
        CH_PLUS:  stack_push(lhs + rhs);
        CH_MINUS: stack_push(lhs - rhs);
        CH_STAR:  stack_push(lhs * rhs);
        CH_SLASH: begin
          if (rhs == '0) begin
            note_status(ST_DIVZ);
            stack_push('0);
          end else begin
            // 64-bit divide so most negative by minus one wraps cleanly
            quotient = longint'($signed(lhs)) / longint'($signed(rhs));
            stack_push(quotient[VAL_W-1:0]);
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      res.value = '0;
      if (model_depth == 0) begin
        note_status(ST_UNDER);
      end else begin
        res.value = model_stack[model_depth-1];
      end
      res.status = model_status;
      expected_results.push_back(res);
      model_depth  = 0;
      model_status = ST_OK;
    end
  endfunction

  // Mostly short idle runs, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic queue_symbol(logic [7:0] sym, logic fin);
    feed_item_t item;
    item.symbol = sym;
    item.last   = fin;
    pending_items.push_back(item);
  endtask

  // Queue a string as one expression, last flag on its final character
  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_symbol(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] random_operator();
    int         r;
    logic [7:0] sym;
    r = $urandom_range(0, 19);
    if (r < 5) return CH_PLUS;
    if (r < 10) return CH_MINUS;
    if (r < 15) return CH_STAR;
    if (r < 19) return CH_SLASH;
    // Any other symbol pops two and pushes nothing
    sym = 8'($urandom_range(0, 255));
    if (sym >= CH_0 && sym <= CH_9) sym = sym ^ 8'h80;
    return sym;
  endfunction

  // Driver: present queued transactions with random gaps
  int gap_left = 0;
  int calm_items = 0;

  always @(posedge clk) begin
    feed_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        evaluate_symbol(in_symbol, in_last);
        items_accepted++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item = pending_items.pop_front();
        in_symbol <= item.symbol;
        in_last   <= item.last;
        in_valid  <= 1'b1;
        if (calm_items > 0) begin
          calm_items <= calm_items - 1;
          gap_left   <= 0;
        end else begin
          gap_left <= pick_gap();
          if ($urandom_range(0, 29) == 0) calm_items <= 40;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random runs, calm stretches and one long hold
  int stall_left = 0;
  int calm_cycles = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!long_hold_done && results_checked >= 8) begin
      // back the block up so it stalls its input
      long_hold_done <= 1'b1;
      out_stall      <= 1'b1;
      stall_left     <= LONG_HOLD_CYCLES;
    end else if (calm_cycles > 0) begin
      out_stall   <= 1'b0;
      calm_cycles <= calm_cycles - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
      if ($urandom_range(0, 39) == 0) calm_cycles <= 200;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_result
    eval_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (expected_results.size() == 0) begin
        $error("out_value: no result expected, actual value %0d status %0d",
               out_value, out_status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value) begin
          $error("out_value mismatch: expected %0d, actual %0d", want.value, out_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status mismatch: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : run
    int         directed_count;
    int         mode;
    int         peak;
    int         depth;
    int         len;
    logic [7:0] sym;

    // Digit extremes
    queue_text("9");
    queue_text("0");
    // Each operator, negative results, truncation toward zero
    queue_text("34+");
    queue_text("91-");
    queue_text("67*");
    queue_text("270-/");
    // Divide by zero pushes zero
    queue_text("05/");
    // Underflow on an operator still pushes
    queue_text("+");
    // Other symbol on an empty stack, top code
    queue_symbol(8'hFF, 1'b1);
    // Empty stack at the end after clean pops
    queue_symbol("1", 1'b0);
    queue_symbol("1", 1'b0);
    queue_symbol(8'h00, 1'b1);
    // Sticky error: divide by zero then underflow
    queue_text("05/+");
    // Most negative divided by minus one
    queue_text("10-28*8*8*8*8*8*8*8*8*8*/");
    // Overflow: 33 pushes, the last one dropped
    queue_text("123456789123456789123456789123456");
    directed_count = pending_items.size();

    while (pending_items.size() < directed_count + RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        // noise: arbitrary bytes, arbitrary last flags
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          queue_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
        end
      end else if (mode == 1) begin
        // broken: legal symbols in a random order
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1)) sym = CH_0 + 8'($urandom_range(0, 9));
          else sym = random_operator();
          queue_symbol(sym, i == len - 1);
        end
      end else begin
        // well-formed: grow to a peak depth, then fold down to one value
        peak  = ($urandom_range(0, 14) == 0) ? $urandom_range(28, 35) : $urandom_range(1, 6);
        depth = 0;
        while (depth < peak) begin
          if (depth >= 2 && $urandom_range(0, 3) == 0) begin
            queue_symbol(random_operator(), 1'b0);
            depth--;
          end else begin
            queue_symbol(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
            depth++;
          end
        end
        while (depth > 1) begin
          queue_symbol(random_operator(), 1'b0);
          depth--;
        end
        pending_items[pending_items.size() - 1].last = 1'b1;
      end
    end
    total_items = pending_items.size();

    while (!(items_accepted == total_items && expected_results.size() == 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
